// ----- rtl/deadband_expo_input_conditioner_top_assert.svh -----
// Assertion macros for the axis conditioner.
// Each macro takes a label, clock, active-low reset, a trigger, a check and a message.
`ifndef DEADBAND_EXPO_INPUT_CONDITIONER_TOP_ASSERT_SVH
`define DEADBAND_EXPO_INPUT_CONDITIONER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Check holds in the same cycle as the trigger
`define DEIC_ASSERT_IMPL(lbl, clk, rst_n, cond, chk, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (chk)) \
        else $error(msg);
// Check holds in the cycle after the trigger
`define DEIC_ASSERT_NEXT(lbl, clk, rst_n, cond, chk, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (chk)) \
        else $error(msg);
`else
`define DEIC_ASSERT_IMPL(lbl, clk, rst_n, cond, chk, msg)
`define DEIC_ASSERT_NEXT(lbl, clk, rst_n, cond, chk, msg)
`endif

`endif

// ----- rtl/deic_pkg.sv -----
package deic_pkg;

    // Sample format: signed Q1.15
    localparam int SAMPLE_W    = 16;
    localparam int FRAC_W      = SAMPLE_W - 1;
    localparam int MAX_INT_EXP = 15;

    // Register widths
    localparam int DB_W       = 15;
    localparam int EXP_W      = 12;
    localparam int EXP_FRAC_W = 8;
    localparam int IPART_W    = EXP_W - EXP_FRAC_W;
    localparam int LIM_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Unsigned magnitude / fraction values up to and including 1.0
    localparam int MAG_W = SAMPLE_W;
    localparam logic [MAG_W-1:0] ONE_FX = {1'b1, {FRAC_W{1'b0}}};

    // Exponent 1.0 in Q4.8 and reset limits
    localparam logic [EXP_W-1:0]        EXP_ONE = {{(IPART_W-1){1'b0}}, 1'b1,
                                                  {EXP_FRAC_W{1'b0}}};
    localparam logic signed [LIM_W-1:0] RST_MIN = '0;
    localparam logic signed [LIM_W-1:0] RST_MAX = {1'b0, {(LIM_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Divider: one quotient bit per step, four steps per stage
    localparam int DIV_STEPS           = FRAC_W + 1;
    localparam int DIV_STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES          = DIV_STEPS / DIV_STEPS_PER_STAGE;

    // Pipeline stage map
    localparam int ST_ENTRY     = 0;
    localparam int ST_DIV_FIRST = ST_ENTRY + 1;
    localparam int ST_DIV_LAST  = ST_DIV_FIRST + DIV_STAGES - 1;
    localparam int ST_POW_FIRST = ST_DIV_LAST + 1;
    localparam int ST_POW_LAST  = ST_POW_FIRST + MAX_INT_EXP - 1;
    localparam int ST_BLEND     = ST_POW_LAST + 1;
    localparam int ST_SPAN      = ST_BLEND + 1;
    localparam int ST_OUT       = ST_SPAN + 1;
    localparam int NUM_STAGES   = ST_OUT + 1;

    // Register index: bit 2 picks the side, low bits pick the field
    typedef enum logic [1:0] {
        FLD_DEADBAND = 2'd0,
        FLD_EXPONENT = 2'd1,
        FLD_MIN      = 2'd2,
        FLD_MAX      = 2'd3
    } t_cfg_field;

    typedef struct packed {
        logic [DB_W-1:0]         deadband;
        logic [EXP_W-1:0]        exponent;
        logic signed [LIM_W-1:0] lo;
        logic signed [LIM_W-1:0] hi;
    } t_side_cfg;

    // Per-transaction payload carried down the pipeline
    typedef struct packed {
        logic                       neg;
        logic                       zero;
        logic [IPART_W-1:0]         ipart;
        logic [EXP_FRAC_W-1:0]      frac;
        logic signed [LIM_W-1:0]    lo;
        logic [LIM_W-1:0]           span;
        logic [MAG_W-1:0]           divisor;
        logic [MAG_W-1:0]           rem;
        logic [MAG_W-1:0]           quo;
        logic [MAG_W-1:0]           prod;
        logic [MAG_W-1:0]           blend;
        logic signed [SAMPLE_W-1:0] res;
    } t_item;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [MAG_W-1:0] quo;
    } t_div;

    // One restoring division step; the first step compares without a shift
    function automatic t_div div_step(t_div cur, logic [MAG_W-1:0] divisor, logic first);
        logic [MAG_W:0] trial;
        t_div           nxt;
        trial   = first ? {1'b0, cur.rem} : {cur.rem, 1'b0};
        nxt.quo = {cur.quo[MAG_W-2:0], 1'b0};
        nxt.rem = trial[MAG_W-1:0];
        if (trial >= {1'b0, divisor}) begin
            nxt.rem    = MAG_W'(trial - {1'b0, divisor});
            nxt.quo[0] = 1'b1;
        end
        return nxt;
    endfunction

    // Unsigned fixed-point product, truncated to FRAC_W fraction bits
    function automatic logic [MAG_W-1:0] mul_fx(logic [MAG_W-1:0] a, logic [MAG_W-1:0] b);
        logic [2*MAG_W-1:0] full;
        full = (2*MAG_W)'(a) * (2*MAG_W)'(b);
        return full[FRAC_W +: MAG_W];
    endfunction

endpackage

// ----- rtl/deadband_expo_input_conditioner_top.sv -----
// Deadband / exponential response conditioner for one joystick axis.
//
// Input channel: i_in_valid / o_in_ready carry one signed Q1.15 sample in
// i_sample. Output channel: o_out_valid / i_out_ready carry the shaped
// Q1.15 value in o_shaped. A transaction completes when valid and ready are
// both high at a rising edge.
// Configuration: i_cfg_wr_en writes i_cfg_data into register i_cfg_index
// (0..3 positive side deadband/exponent/min/max, 4..7 the negative side) at
// the clock edge; settings must change only while the pipeline is empty.
// Pipeline: o_out_valid rises once the sample has passed through all
// 23 stages: one entry stage, a 4-stage divider (4 quotient bits per stage),
// a 15-stage power chain (one multiplier per stage, one per integer exponent
// step), blend and span multiplier stages, and the output add/saturate stage.
// Throughput: one sample per cycle while the receiver is ready. Each stage
// has its own valid bit and advances when it is empty or the stage after it
// advances, so bubbles close up and a stalled receiver only backs up the
// pipeline; nothing is lost or repeated. Up to 23 samples are held while it stalls.
// Reset (synchronous, active low) empties the pipeline and restores the
// settings to deadband 0, exponent 1.0, min 0, max full scale.

`include "deadband_expo_input_conditioner_top_assert.svh"

module deadband_expo_input_conditioner_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [deic_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [deic_pkg::SAMPLE_W-1:0]   o_shaped,
    input  logic                                   i_cfg_wr_en,
    input  logic [deic_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [deic_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int LAST = deic_pkg::NUM_STAGES - 1;

    deic_pkg::t_side_cfg r_cfg [2];

    logic [deic_pkg::NUM_STAGES-1:0] r_vld;
    logic [deic_pkg::NUM_STAGES-1:0] n_vld;
    logic [deic_pkg::NUM_STAGES-1:0] stage_en;
    deic_pkg::t_item                 r_pipe [deic_pkg::NUM_STAGES];
    deic_pkg::t_item                 n_pipe [deic_pkg::NUM_STAGES];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 2; s++) begin
                r_cfg[s].deadband <= '0;
                r_cfg[s].exponent <= deic_pkg::EXP_ONE;
                r_cfg[s].lo       <= deic_pkg::RST_MIN;
                r_cfg[s].hi       <= deic_pkg::RST_MAX;
            end
        end else if (i_cfg_wr_en) begin
            case (deic_pkg::t_cfg_field'(i_cfg_index[1:0]))
                deic_pkg::FLD_DEADBAND: begin
                    r_cfg[i_cfg_index[2]].deadband <= i_cfg_data[deic_pkg::DB_W-1:0];
                end
                deic_pkg::FLD_EXPONENT: begin
                    r_cfg[i_cfg_index[2]].exponent <= i_cfg_data[deic_pkg::EXP_W-1:0];
                end
                deic_pkg::FLD_MIN: begin
                    r_cfg[i_cfg_index[2]].lo <= $signed(i_cfg_data[deic_pkg::LIM_W-1:0]);
                end
                deic_pkg::FLD_MAX: begin
                    r_cfg[i_cfg_index[2]].hi <= $signed(i_cfg_data[deic_pkg::LIM_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // Entry stage: side select, magnitude, deadband test, range/exponent prep
    deic_pkg::t_side_cfg               sel_cfg;
    logic                              in_neg;
    logic [deic_pkg::MAG_W-1:0]        raw;
    logic [deic_pkg::MAG_W-1:0]        mag;
    logic [deic_pkg::MAG_W-1:0]        db;
    logic signed [deic_pkg::LIM_W-1:0] lim_lo;
    logic signed [deic_pkg::LIM_W-1:0] lim_hi;
    logic signed [deic_pkg::LIM_W:0]   span_full;
    logic [deic_pkg::EXP_W-1:0]        exp_clamped;
    deic_pkg::t_item                   n_entry;

    always_comb begin
        raw     = i_sample;
        in_neg  = i_sample[deic_pkg::SAMPLE_W-1];
        sel_cfg = r_cfg[in_neg];
        mag     = in_neg ? (~raw + deic_pkg::MAG_W'(1)) : raw;
        db      = {1'b0, sel_cfg.deadband};

        // min above max: swap
        if (sel_cfg.lo > sel_cfg.hi) begin
            lim_lo = sel_cfg.hi;
            lim_hi = sel_cfg.lo;
        end else begin
            lim_lo = sel_cfg.lo;
            lim_hi = sel_cfg.hi;
        end
        span_full = (deic_pkg::LIM_W+1)'(lim_hi) - (deic_pkg::LIM_W+1)'(lim_lo);

        // exponent below 1.0 counts as 1.0; a 4-bit integer part never exceeds the cap
        exp_clamped = (sel_cfg.exponent < deic_pkg::EXP_ONE) ? deic_pkg::EXP_ONE
                                                              : sel_cfg.exponent;

        n_entry.neg     = in_neg;
        n_entry.zero    = (raw == '0) || (mag < db);
        n_entry.ipart   = exp_clamped[deic_pkg::EXP_W-1:deic_pkg::EXP_FRAC_W];
        n_entry.frac    = exp_clamped[deic_pkg::EXP_FRAC_W-1:0];
        n_entry.lo      = lim_lo;
        n_entry.span    = span_full[deic_pkg::LIM_W-1:0];
        n_entry.divisor = deic_pkg::ONE_FX - db;
        n_entry.rem     = mag - db;
        n_entry.quo     = '0;
        n_entry.prod    = deic_pkg::ONE_FX;
        n_entry.blend   = '0;
        n_entry.res     = '0;
    end

    // Datapath stages after entry
    deic_pkg::t_div                       dv;
    logic [deic_pkg::IPART_W-1:0]         pow_idx;
    logic [deic_pkg::EXP_FRAC_W:0]        inv_frac;
    logic [deic_pkg::MAG_W+8:0]           blend_sum;
    logic signed [deic_pkg::SAMPLE_W+1:0] sum;
    logic signed [deic_pkg::SAMPLE_W+1:0] y;

    always_comb begin
        dv        = '0;
        pow_idx   = '0;
        inv_frac  = '0;
        blend_sum = '0;
        sum       = '0;
        y         = '0;
        n_pipe[0] = n_entry;
        for (int k = 1; k < deic_pkg::NUM_STAGES; k++) begin
            n_pipe[k] = r_pipe[k-1];

            // t = (|x| - db) / (1 - db), four quotient bits per stage
            if (k >= deic_pkg::ST_DIV_FIRST && k <= deic_pkg::ST_DIV_LAST) begin
                dv.rem = r_pipe[k-1].rem;
                dv.quo = r_pipe[k-1].quo;
                for (int j = 0; j < deic_pkg::DIV_STEPS_PER_STAGE; j++) begin
                    dv = deic_pkg::div_step(dv, r_pipe[k-1].divisor,
                                            (k == deic_pkg::ST_DIV_FIRST) && (j == 0));
                end
                n_pipe[k].rem = dv.rem;
                n_pipe[k].quo = dv.quo;
            end

            // t^ipart, one factor per stage
            if (k >= deic_pkg::ST_POW_FIRST && k <= deic_pkg::ST_POW_LAST) begin
                pow_idx = deic_pkg::IPART_W'(k - deic_pkg::ST_POW_FIRST);
                if (pow_idx < r_pipe[k-1].ipart) begin
                    n_pipe[k].prod = deic_pkg::mul_fx(r_pipe[k-1].prod, r_pipe[k-1].quo);
                end
                // linear blend frac*t + (1-frac), alongside the first factor
                if (k == deic_pkg::ST_POW_FIRST) begin
                    inv_frac  = (deic_pkg::EXP_FRAC_W+1)'(1 << deic_pkg::EXP_FRAC_W)
                              - {1'b0, r_pipe[k-1].frac};
                    blend_sum = (deic_pkg::MAG_W+9)'(r_pipe[k-1].frac)
                              * (deic_pkg::MAG_W+9)'(r_pipe[k-1].quo)
                              + ((deic_pkg::MAG_W+9)'(inv_frac) << deic_pkg::FRAC_W);
                    n_pipe[k].blend = blend_sum[deic_pkg::EXP_FRAC_W +: deic_pkg::MAG_W];
                end
            end

            if (k == deic_pkg::ST_BLEND) begin
                n_pipe[k].prod = deic_pkg::mul_fx(r_pipe[k-1].prod, r_pipe[k-1].blend);
            end

            if (k == deic_pkg::ST_SPAN) begin
                n_pipe[k].prod = deic_pkg::mul_fx(r_pipe[k-1].prod, r_pipe[k-1].span);
            end

            // offset, sign and saturation
            if (k == deic_pkg::ST_OUT) begin
                sum = (deic_pkg::SAMPLE_W+2)'(r_pipe[k-1].lo)
                    + $signed({2'b00, r_pipe[k-1].prod});
                y   = r_pipe[k-1].neg ? -sum : sum;
                if (r_pipe[k-1].zero) begin
                    n_pipe[k].res = '0;
                end else if (y > (deic_pkg::SAMPLE_W+2)'(deic_pkg::SAT_MAX)) begin
                    n_pipe[k].res = deic_pkg::SAT_MAX;
                end else if (y < (deic_pkg::SAMPLE_W+2)'(deic_pkg::SAT_MIN)) begin
                    n_pipe[k].res = deic_pkg::SAT_MIN;
                end else begin
                    n_pipe[k].res = y[deic_pkg::SAMPLE_W-1:0];
                end
            end
        end
    end

    // Stage advance: a stage loads when empty or when its successor loads
    always_comb begin
        stage_en[LAST] = !r_vld[LAST] || i_out_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
        n_vld = {r_vld[LAST-1:0], i_in_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < deic_pkg::NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < deic_pkg::NUM_STAGES; k++) begin
            if (stage_en[k]) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
    end

    assign o_in_ready  = stage_en[0];
    assign o_out_valid = r_vld[LAST];
    assign o_shaped    = r_pipe[LAST].res;

    // Check terms
    logic chk_in_fire;
    logic chk_entry_vld;
    logic chk_quo_en;
    logic chk_quo_ok;
    logic chk_pow_en;
    logic chk_pow_ok;

    assign chk_in_fire   = i_in_valid && o_in_ready;
    assign chk_entry_vld = r_vld[deic_pkg::ST_ENTRY];
    assign chk_quo_en    = r_vld[deic_pkg::ST_DIV_LAST] && !r_pipe[deic_pkg::ST_DIV_LAST].zero;
    assign chk_quo_ok    = r_pipe[deic_pkg::ST_DIV_LAST].quo <= deic_pkg::ONE_FX;
    assign chk_pow_en    = r_vld[deic_pkg::ST_POW_LAST] && !r_pipe[deic_pkg::ST_POW_LAST].zero;
    assign chk_pow_ok    = (r_pipe[deic_pkg::ST_POW_LAST].prod <= deic_pkg::ONE_FX)
                        && (r_pipe[deic_pkg::ST_POW_LAST].blend <= deic_pkg::ONE_FX);

    // Checks
    `DEIC_ASSERT_IMPL(a_ready_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready, "input blocked")
    `DEIC_ASSERT_NEXT(a_accept_in, i_clk, i_rst_n, chk_in_fire, chk_entry_vld, "lost at entry")
    `DEIC_ASSERT_IMPL(a_quotient_bound, i_clk, i_rst_n, chk_quo_en, chk_quo_ok, "t above 1.0")
    `DEIC_ASSERT_IMPL(a_power_bound, i_clk, i_rst_n, chk_pow_en, chk_pow_ok, "power above 1.0")

endmodule
